/* rtl/atrlm_pkg.sv */
// atrlm_pkg: shared types and constants of the modem reply line matcher
// reply state codes, expected reply texts, control char codes, matcher control struct
// no dependencies
`default_nettype none

package atrlm_pkg;

	typedef logic [1:0] reply_t;
	localparam reply_t RS_NONE  = 2'd0;
	localparam reply_t RS_OK    = 2'd1;
	localparam reply_t RS_ERROR = 2'd2;

	localparam int TEXT_MAX   = 12;
	localparam int TEXT_COUNT = 9;

	typedef logic [TEXT_MAX*8-1:0] window_t;
	typedef logic [TEXT_COUNT-1:0] hits_t;
	typedef logic [3:0]            tlen_t;

	localparam int T_OK        = 0;
	localparam int T_SMS       = 1;
	localparam int T_CONN_OK   = 2;
	localparam int T_PROMPT    = 3;
	localparam int T_SEND_OK   = 4;
	localparam int T_SHUT_OK   = 5;
	localparam int T_CPIN      = 6;
	localparam int T_CONN_FAIL = 7;
	localparam int T_CLOSED    = 8;
	localparam int NO_TEXT     = -1;

	// most recent byte sits in the low byte, as in a string literal
	localparam window_t TEXT_PAT [TEXT_COUNT] = '{
		window_t'("OK"),
		window_t'("SMS Ready"),
		window_t'("CONNECT OK"),
		window_t'(">"),
		window_t'("SEND OK"),
		window_t'("SHUT OK"),
		window_t'("+CPIN: READY"),
		window_t'("CONNECT FAIL"),
		window_t'("CLOSED")
	};

	localparam tlen_t TEXT_LEN [TEXT_COUNT] = '{
		4'd2, 4'd9, 4'd10, 4'd1, 4'd7, 4'd7, 4'd12, 4'd12, 4'd6
	};

	localparam int MAX_ENTRIES = 16;

	localparam int ENTRY_TEXT [MAX_ENTRIES] = '{
		T_OK, T_SMS, T_CONN_OK, T_PROMPT, T_SEND_OK, T_SHUT_OK,
		T_CONN_OK, T_OK, T_OK, T_CPIN,
		NO_TEXT, NO_TEXT, NO_TEXT, NO_TEXT, NO_TEXT, NO_TEXT
	};

	localparam int REPORTED_ENTRIES = 11;
	localparam int CONNECT_ENTRY    = 2;
	localparam int PROMPT_ENTRY     = 3;

	localparam int SHORT_LINE_LEN  = 4;
	localparam int DATA_LEN_FLOOR  = 15;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_SP = 8'h20;

	typedef struct packed {
		logic push;
		logic restart;
		logic flush;
	} match_ctl_t;

	function automatic window_t text_mask(tlen_t n);
		window_t m;
		m = '0;
		for (int k = 0; k < TEXT_MAX; k++) begin
			if (k < int'(n)) begin
				m[k*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/atrlm_matcher.sv */
// atrlm_matcher: running substring search of the expected texts over the current line
// keeps the last bytes of the line and a sticky found flag per text; uses atrlm_pkg
`default_nettype none

module atrlm_matcher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire atrlm_pkg::match_ctl_t ctl,
	input  wire logic [7:0]          rx_byte,
	output atrlm_pkg::hits_t         hits
);

	localparam atrlm_pkg::tlen_t CNT_SAT = 4'(atrlm_pkg::TEXT_MAX);

	atrlm_pkg::window_t win_q;
	atrlm_pkg::window_t win_new;
	atrlm_pkg::tlen_t   cnt_q;
	atrlm_pkg::tlen_t   cnt_base;
	atrlm_pkg::tlen_t   cnt_new;
	atrlm_pkg::hits_t   found_q;
	atrlm_pkg::hits_t   hit_now;

	always_comb begin
		win_new  = {win_q[atrlm_pkg::TEXT_MAX*8-9:0], rx_byte};
		cnt_base = ctl.restart ? '0 : cnt_q;
		cnt_new  = (cnt_base == CNT_SAT) ? CNT_SAT : cnt_base + 4'd1;
		for (int t = 0; t < atrlm_pkg::TEXT_COUNT; t++) begin
			hit_now[t] = (cnt_new >= atrlm_pkg::TEXT_LEN[t]) &&
				(((win_new ^ atrlm_pkg::TEXT_PAT[t]) &
				atrlm_pkg::text_mask(atrlm_pkg::TEXT_LEN[t])) == '0);
		end
		hits = (ctl.restart ? '0 : found_q) | hit_now;
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= win_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= '0;
		end else if (ctl.push) begin
			if (ctl.flush) begin
				cnt_q   <= '0;
				found_q <= '0;
			end else begin
				cnt_q   <= cnt_new;
				found_q <= hits;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/at_reply_line_matcher_top.sv */
// at_reply_line_matcher_top: modem reply line matcher, top level
// line store memory, entry reply states, dump sequencer; uses atrlm_pkg, atrlm_matcher
//
// Input channel (in_valid/in_ready): one beat is a received modem byte or a clear of
// one entry's reply state. Output channel (out_valid/out_ready): every input beat
// gives one status beat (kind 0); a line of more than 15 bytes ending in a bare LF
// is then dumped from the line store as data beats (kind 1), the LF included, with
// last set on the final beat of the run. reply_states always shows the entry states
// after the most recent input beat.
// The status beat is valid the cycle after the input beat is taken.
// Throughput: one input beat per cycle while out_ready is high and no dump runs.
// During a dump the single-port line store is read once per byte, the registered read
// data feeding the output register. in_ready is low for the whole dump.
// Reset clears the line length, all entry states and the output valid flag; the line
// store is not cleared since only bytes written in the current line are read.
// When out_ready is low the output register holds its beat, the dump sequencer
// stalls and in_ready drops; no beat is lost.
`default_nettype none

module at_reply_line_matcher_top #(
	parameter int LINE_CAPACITY = 32,
	parameter int ENTRY_COUNT   = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [3:0]  entry_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [7:0]       line_byte,
	output logic             last,
	output logic [21:0]      reply_states,
	output logic             prompt_seen,
	output logic             closed_seen
);

	localparam int LW = $clog2(LINE_CAPACITY + 1);
	localparam int AW = $clog2(LINE_CAPACITY);
	localparam logic [LW-1:0] CAP_L   = LW'(LINE_CAPACITY);
	localparam logic [LW-1:0] SHORT_L = LW'(atrlm_pkg::SHORT_LINE_LEN);
	localparam logic [LW-1:0] DATA_L  = LW'(atrlm_pkg::DATA_LEN_FLOOR);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic                 state_q;
	logic [LW-1:0]        len_q;
	logic [7:0]           prev_q;
	atrlm_pkg::reply_t    st_q [ENTRY_COUNT];
	logic [7:0]           mem [LINE_CAPACITY];

	logic                 out_free;
	logic                 accept;
	logic                 byte_beat;
	logic                 wrap;
	logic [LW-1:0]        len_eff;
	logic [LW-1:0]        len_new;
	logic                 has_prev;
	logic                 prompt_c;
	logic                 short_c;
	logic                 line_c;
	logic                 dump_c;
	logic                 line_done;
	logic                 clr_ok;
	atrlm_pkg::hits_t     hits;
	atrlm_pkg::match_ctl_t mctl;

	logic [LW-1:0]        rd_left_q;
	logic [AW-1:0]        rd_addr_q;
	logic                 rd_pend_s1;
	logic                 rd_last_s1;
	logic [7:0]           rd_data_s1;
	logic                 load_rd;
	logic                 issue;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [7:0]           line_byte_q;
	logic                 last_q;
	logic                 prompt_q;
	logic                 closed_q;

	always_comb begin
		out_free  = !out_valid_q || out_ready;
		in_ready  = (state_q == ST_IDLE) && out_free;
		accept    = in_valid && in_ready;
		byte_beat = accept && !operation;
		wrap      = (len_q >= CAP_L);
		len_eff   = wrap ? '0 : len_q;
		len_new   = len_eff + LW'(1);
		has_prev  = (len_new >= LW'(2));
		prompt_c  = has_prev && (prev_q == atrlm_pkg::CH_GT) && (rx_byte == atrlm_pkg::CH_SP);
		short_c   = has_prev && (len_new < SHORT_L) &&
			(prev_q == atrlm_pkg::CH_CR) && (rx_byte == atrlm_pkg::CH_LF);
		line_c    = (len_new >= SHORT_L) &&
			(prev_q == atrlm_pkg::CH_CR) && (rx_byte == atrlm_pkg::CH_LF);
		dump_c    = (len_new > DATA_L) &&
			(prev_q != atrlm_pkg::CH_CR) && (rx_byte == atrlm_pkg::CH_LF);
		line_done = prompt_c || short_c || line_c || dump_c;
		clr_ok    = ({1'b0, entry_index} < 5'(ENTRY_COUNT));
		mctl.push    = byte_beat;
		mctl.restart = wrap;
		mctl.flush   = line_done;
	end

	atrlm_matcher u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mctl),
		.rx_byte (rx_byte),
		.hits    (hits)
	);

	// line store
	always_ff @(posedge clk) begin
		if (byte_beat) begin
			mem[len_eff[AW-1:0]] <= rx_byte;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_beat) begin
			prev_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (byte_beat) begin
			len_q <= line_done ? '0 : len_new;
		end
	end

	// entry reply states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				st_q[i] <= atrlm_pkg::RS_NONE;
			end
		end else if (accept) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				if (operation) begin
					if (clr_ok && (entry_index == 4'(i))) begin
						st_q[i] <= atrlm_pkg::RS_NONE;
					end
				end else begin
					if (prompt_c && (i == atrlm_pkg::PROMPT_ENTRY)) begin
						st_q[i] <= atrlm_pkg::RS_OK;
					end
					if (line_c) begin
						if ((atrlm_pkg::ENTRY_TEXT[i] != atrlm_pkg::NO_TEXT) &&
							hits[(atrlm_pkg::ENTRY_TEXT[i] == atrlm_pkg::NO_TEXT) ?
							0 : atrlm_pkg::ENTRY_TEXT[i]]) begin
							st_q[i] <= atrlm_pkg::RS_OK;
						end
						if ((i == atrlm_pkg::CONNECT_ENTRY) &&
							hits[atrlm_pkg::T_CONN_FAIL]) begin
							st_q[i] <= atrlm_pkg::RS_ERROR;
						end
					end
				end
			end
		end
	end

	// dump sequencer
	always_comb begin
		load_rd = rd_pend_s1 && out_free;
		issue   = (state_q == ST_DUMP) && (rd_left_q != '0) && (!rd_pend_s1 || load_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_left_q  <= '0;
			rd_addr_q  <= '0;
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (byte_beat && dump_c) begin
						state_q   <= ST_DUMP;
						rd_left_q <= len_new;
						rd_addr_q <= '0;
					end
				end
				ST_DUMP: begin
					if (issue) begin
						rd_left_q  <= rd_left_q - LW'(1);
						rd_addr_q  <= rd_addr_q + AW'(1);
						rd_pend_s1 <= 1'b1;
						rd_last_s1 <= (rd_left_q == LW'(1));
					end else if (load_rd) begin
						rd_pend_s1 <= 1'b0;
					end
					if (load_rd && rd_last_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept || load_rd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= 1'b0;
			line_byte_q <= 8'd0;
			last_q      <= !(byte_beat && dump_c);
			prompt_q    <= byte_beat && prompt_c;
			closed_q    <= byte_beat && line_c && hits[atrlm_pkg::T_CLOSED];
		end else if (load_rd) begin
			kind_q      <= 1'b1;
			line_byte_q <= rd_data_s1;
			last_q      <= rd_last_s1;
			prompt_q    <= 1'b0;
			closed_q    <= 1'b0;
		end
	end

	always_comb begin
		out_valid   = out_valid_q;
		kind        = kind_q;
		line_byte   = line_byte_q;
		last        = last_q;
		prompt_seen = prompt_q;
		closed_seen = closed_q;
		for (int i = 0; i < atrlm_pkg::REPORTED_ENTRIES; i++) begin
			reply_states[2*i +: 2] = st_q[i];
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP_L)
		else $error("line length beyond capacity");

	a_pend_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == ST_DUMP))
		else $error("read pending outside dump");

	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_beat && dump_c) |=> ((state_q == ST_DUMP) && out_valid && !last && !kind))
		else $error("dump did not start with an open status beat");

	a_open_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind && !last) |-> (state_q == ST_DUMP))
		else $error("status beat without last outside dump");

	a_status_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (line_byte == 8'd0))
		else $error("status beat carries a data byte");

endmodule

`default_nettype wire
